// ----- hw/rtl/rmc_pkg.sv -----
// Package for the RMS current meter: constants, register indexes, job and state types.
`default_nettype none
package rmc_pkg;

  localparam int CHANNELS  = 8;
  localparam int ADC_BITS  = 12;
  localparam int CH_W      = 8;
  localparam int OFS_W     = ADC_BITS + 16;
  localparam int MAG_W     = ADC_BITS + 8;
  localparam int SQ_W      = 2 * MAG_W;
  localparam int SUM_W     = SQ_W + 17;
  localparam int CNT_W     = 17;
  localparam int MEAN_W    = SQ_W;
  localparam int RAD_W     = MEAN_W + 16;
  localparam int ROOT_W    = RAD_W / 2;
  localparam int REM_W     = ROOT_W + 1;
  localparam int PROD_W    = ROOT_W + 32;
  localparam int AMPS_W    = PROD_W - 16;
  localparam int PWR_W     = 42;
  localparam int STEP_W    = 6;
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = 1;
  localparam int QCNT_W    = 2;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_MODE         = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIXED_OFFSET = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE        = 8'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_VOLTAGE = 8'd4;

  localparam logic MODE_TRACK = 1'b0;
  localparam logic MODE_FIXED = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [11:0] fixed_offset;
    logic [15:0] sample_count;
    logic [31:0] scale;
    logic [9:0]  line_voltage;
  } cfg_t;

  typedef struct packed {
    logic             err;
    logic [CH_W-1:0]  ch;
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] n;
  } job_t;

  typedef enum logic [2:0] {
    F_IDLE, F_OFS, F_DIFF, F_SQR, F_ACC, F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE, B_DIV, B_SQRT, B_MUL, B_SAT, B_PWR, B_OUT
  } back_state_t;

endpackage
`default_nettype wire

// ----- hw/rtl/rmc_if.sv -----
// Channel interfaces of the RMS current meter: sample input, result output, register writes.
`default_nettype none
interface rmc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] channel;
  logic [11:0] sample;
  modport source (output valid, channel, sample, input ready);
  modport sink   (input valid, channel, sample, output ready);
endinterface

interface rmc_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  result_channel;
  logic [31:0] irms;
  logic [41:0] power;
  logic        error;
  modport source (output valid, result_channel, irms, power, error, input ready);
  modport sink   (input valid, result_channel, irms, power, error, output ready);
endinterface

interface rmc_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/rms_current_meter_top.sv -----
// Top level of the RMS current meter: register file and the front, queue and back ends.
// The front end takes a sample through accept, offset update, difference, square and sum,
// then hands a finished window or an error to the two-entry queue in a push state that waits
// while the queue is full; an out-of-range channel goes from accept straight to the hand-over.
// A window result then passes through the back end: taking the job, bit-serial division of the
// 57-bit square sum by the sample count, digit-by-digit square root to a 28-bit root, then
// scaling, saturation, power and the output register. The output register holds for as long
// as the receiver stalls. Samples keep flowing into the next window while the back end works;
// the queue fills only when results arrive faster than the back end and the output side drain
// them. Register writes are always accepted and must be made only while the block is idle.
`default_nettype none
module rms_current_meter_top
  import rmc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  rmc_in_if.sink     in_if,
  rmc_out_if.source  out_if,
  rmc_cfg_if.sink    cfg_if
);

  cfg_t cfg_r, cfg_nxt;
  logic push, pop, full, empty;
  job_t wr_job, rd_job;

  assign cfg_if.ready = 1'b1;

  // decode register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_if.valid) begin
      case (cfg_if.index)
        REG_MODE:         cfg_nxt.mode         = cfg_if.data[0];
        REG_FIXED_OFFSET: cfg_nxt.fixed_offset = cfg_if.data[11:0];
        REG_SAMPLE_COUNT: cfg_nxt.sample_count = cfg_if.data[15:0];
        REG_SCALE:        cfg_nxt.scale        = cfg_if.data;
        REG_LINE_VOLTAGE: cfg_nxt.line_voltage = cfg_if.data[9:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode         <= MODE_TRACK;
      cfg_r.fixed_offset <= 12'd2048;
      cfg_r.sample_count <= 16'd1024;
      cfg_r.scale        <= 32'd65536;
      cfg_r.line_voltage <= 10'd230;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  rmc_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_r),
    .in_if (in_if),
    .push  (push),
    .job   (wr_job),
    .full  (full)
  );

  rmc_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_job (wr_job),
    .full   (full),
    .pop    (pop),
    .rd_job (rd_job),
    .empty  (empty)
  );

  rmc_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .rd_job (rd_job),
    .empty  (empty),
    .pop    (pop),
    .out_if (out_if)
  );

endmodule
`default_nettype wire

// ----- hw/rtl/rmc_front.sv -----
// Front end: takes samples, checks the channel, removes offset, squares and sums a window.
`default_nettype none
module rmc_front
  import rmc_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire cfg_t         cfg,
  rmc_in_if.sink            in_if,
  output      logic         push,
  output      job_t         job,
  input  wire logic         full
);

  front_state_t state_r, state_nxt;
  logic [CH_W-1:0]     ch_r, ch_nxt;
  logic [11:0]         smp_r, smp_nxt;
  logic                mode_r, mode_nxt;
  logic [OFS_W-1:0]    ofs_r, ofs_nxt;
  logic [MAG_W-1:0]    mag_r, mag_nxt;
  logic [SQ_W-1:0]     sq_r, sq_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [15:0]         cnt_r, cnt_nxt;
  job_t                job_r, job_nxt;

  logic [OFS_W-1:0]    s16;
  logic signed [OFS_W:0] d_ofs, d_new, d_shift;
  logic signed [12:0]  d_fix;
  logic [11:0]         fix_abs;
  logic signed [MAG_W:0] d_trk;
  logic [CNT_W-1:0]    n_win, limit;
  logic [SUM_W-1:0]    sum_tot;

  always_comb begin
    // offset-free difference arithmetic
    s16     = {smp_r, 16'd0};
    d_ofs   = $signed({1'b0, s16}) - $signed({1'b0, ofs_r});
    d_shift = d_ofs >>> 10;
    d_new   = $signed({1'b0, s16}) - $signed({1'b0, ofs_r});
    d_trk   = d_new[OFS_W:8];
    d_fix   = $signed({1'b0, smp_r}) - $signed({1'b0, cfg.fixed_offset});
    fix_abs = d_fix[12] ? 12'(-d_fix) : d_fix[11:0];
    n_win   = {1'b0, cnt_r} + CNT_W'(1);
    limit   = (cfg.sample_count == 16'd0) ? CNT_W'(65536) : {1'b0, cfg.sample_count};
    sum_tot = sum_r + SUM_W'(sq_r);
  end

  always_comb begin
    state_nxt = state_r;
    ch_nxt    = ch_r;
    smp_nxt   = smp_r;
    mode_nxt  = mode_r;
    ofs_nxt   = ofs_r;
    mag_nxt   = mag_r;
    sq_nxt    = sq_r;
    sum_nxt   = sum_r;
    cnt_nxt   = cnt_r;
    job_nxt   = job_r;
    in_if.ready = 1'b0;
    push      = 1'b0;
    case (state_r)
      F_IDLE: begin
        in_if.ready = 1'b1;
        if (in_if.valid) begin
          ch_nxt   = in_if.channel;
          smp_nxt  = in_if.sample;
          mode_nxt = cfg.mode;
          if (32'(in_if.channel) >= CHANNELS) begin
            job_nxt   = '0;
            job_nxt.err = 1'b1;
            state_nxt = F_PUSH;
          end else begin
            state_nxt = F_OFS;
          end
        end
      end
      F_OFS: begin
        // move the tracking estimate a 1/1024 step towards the sample
        if (mode_r == MODE_TRACK) begin
          ofs_nxt = OFS_W'($signed({1'b0, ofs_r}) + d_shift);
        end
        state_nxt = F_DIFF;
      end
      F_DIFF: begin
        if (mode_r == MODE_TRACK) begin
          mag_nxt = d_trk[MAG_W] ? MAG_W'(-d_trk) : d_trk[MAG_W-1:0];
        end else begin
          mag_nxt = {fix_abs, 8'd0};
        end
        state_nxt = F_SQR;
      end
      F_SQR: begin
        sq_nxt    = mag_r * mag_r;
        state_nxt = F_ACC;
      end
      F_ACC: begin
        // close the window or advance the count
        if (n_win >= limit) begin
          job_nxt.err = 1'b0;
          job_nxt.ch  = ch_r;
          job_nxt.sum = sum_tot;
          job_nxt.n   = n_win;
          sum_nxt     = '0;
          cnt_nxt     = '0;
          state_nxt   = F_PUSH;
        end else begin
          sum_nxt   = sum_tot;
          cnt_nxt   = n_win[15:0];
          state_nxt = F_IDLE;
        end
      end
      F_PUSH: begin
        if (!full) begin
          push      = 1'b1;
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      ofs_r   <= OFS_W'(1 << (OFS_W - 1));
      sum_r   <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      ofs_r   <= ofs_nxt;
      sum_r   <= sum_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ch_r   <= ch_nxt;
    smp_r  <= smp_nxt;
    mode_r <= mode_nxt;
    mag_r  <= mag_nxt;
    sq_r   <= sq_nxt;
    job_r  <= job_nxt;
  end

  assign job = job_r;

endmodule
`default_nettype wire

// ----- hw/rtl/rmc_queue.sv -----
// Two-entry job queue between the front end and the back end.
`default_nettype none
module rmc_queue
  import rmc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire job_t wr_job,
  output      logic full,
  input  wire logic pop,
  output      job_t rd_job,
  output      logic empty
);

  job_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign full   = (cnt_r == QCNT_W'(QDEPTH));
  assign empty  = (cnt_r == '0);
  assign rd_job = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? wp_r + QPTR_W'(1) : wp_r;
    rp_nxt  = pop  ? rp_r + QPTR_W'(1) : rp_r;
    cnt_nxt = cnt_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // store the incoming job
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wr_job;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("job queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
    else $error("job queue read while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QDEPTH))
    else $error("job queue count beyond depth");

endmodule
`default_nettype wire

// ----- hw/rtl/rmc_back.sv -----
// Back end: window mean by long division, square root, scaling and power, result register.
`default_nettype none
module rmc_back
  import rmc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire cfg_t cfg,
  input  wire job_t rd_job,
  input  wire logic empty,
  output      logic pop,
  rmc_out_if.source out_if
);

  back_state_t state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [SUM_W-1:0]  quo_r, quo_nxt;
  logic [CNT_W:0]    drem_r, drem_nxt;
  logic [CNT_W-1:0]  n_r, n_nxt;
  logic [RAD_W-1:0]  rad_r, rad_nxt;
  logic [REM_W-1:0]  srem_r, srem_nxt;
  logic [ROOT_W-1:0] root_r, root_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [CH_W-1:0]   ch_r, ch_nxt;
  logic [31:0]       irms_r, irms_nxt;
  logic [PWR_W-1:0]  pwr_r, pwr_nxt;
  logic              err_r, err_nxt;

  logic [CNT_W:0]    d_try;
  logic              d_bit;
  logic [SUM_W-1:0]  quo_step;
  logic [REM_W+1:0]  s_try, s_trial;
  logic              s_bit;
  logic [AMPS_W-1:0] amps;

  always_comb begin
    // one quotient bit and one root bit per cycle
    d_try    = {drem_r[CNT_W-1:0], quo_r[SUM_W-1]};
    d_bit    = (d_try >= {1'b0, n_r});
    quo_step = {quo_r[SUM_W-2:0], d_bit};
    s_try    = {srem_r, rad_r[RAD_W-1 -: 2]};
    s_trial  = (REM_W+2)'({root_r, 2'b01});
    s_bit    = (s_try >= s_trial);
    amps     = prod_r[PROD_W-1:16];
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    quo_nxt   = quo_r;
    drem_nxt  = drem_r;
    n_nxt     = n_r;
    rad_nxt   = rad_r;
    srem_nxt  = srem_r;
    root_nxt  = root_r;
    prod_nxt  = prod_r;
    ch_nxt    = ch_r;
    irms_nxt  = irms_r;
    pwr_nxt   = pwr_r;
    err_nxt   = err_r;
    pop       = 1'b0;
    case (state_r)
      B_IDLE: begin
        if (!empty) begin
          pop = 1'b1;
          if (rd_job.err) begin
            ch_nxt    = '0;
            irms_nxt  = '0;
            pwr_nxt   = '0;
            err_nxt   = 1'b1;
            state_nxt = B_OUT;
          end else begin
            ch_nxt    = rd_job.ch;
            err_nxt   = 1'b0;
            quo_nxt   = rd_job.sum;
            n_nxt     = rd_job.n;
            drem_nxt  = '0;
            step_nxt  = '0;
            state_nxt = B_DIV;
          end
        end
      end
      B_DIV: begin
        quo_nxt  = quo_step;
        drem_nxt = d_bit ? d_try - {1'b0, n_r} : d_try;
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(SUM_W - 1)) begin
          rad_nxt   = {quo_step[MEAN_W-1:0], 16'd0};
          srem_nxt  = '0;
          root_nxt  = '0;
          step_nxt  = '0;
          state_nxt = B_SQRT;
        end
      end
      B_SQRT: begin
        rad_nxt  = {rad_r[RAD_W-3:0], 2'b00};
        srem_nxt = s_bit ? REM_W'(s_try - s_trial) : REM_W'(s_try);
        root_nxt = {root_r[ROOT_W-2:0], s_bit};
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(ROOT_W - 1)) begin
          state_nxt = B_MUL;
        end
      end
      B_MUL: begin
        prod_nxt  = root_r * cfg.scale;
        state_nxt = B_SAT;
      end
      B_SAT: begin
        // saturate the current to 32 bits
        irms_nxt  = (|amps[AMPS_W-1:32]) ? 32'hFFFF_FFFF : amps[31:0];
        state_nxt = B_PWR;
      end
      B_PWR: begin
        pwr_nxt   = irms_r * cfg.line_voltage;
        state_nxt = B_OUT;
      end
      B_OUT: begin
        if (out_if.ready) begin
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    quo_r  <= quo_nxt;
    drem_r <= drem_nxt;
    n_r    <= n_nxt;
    rad_r  <= rad_nxt;
    srem_r <= srem_nxt;
    root_r <= root_nxt;
    prod_r <= prod_nxt;
    ch_r   <= ch_nxt;
    irms_r <= irms_nxt;
    pwr_r  <= pwr_nxt;
    err_r  <= err_nxt;
  end

  assign out_if.valid          = (state_r == B_OUT);
  assign out_if.result_channel = ch_r;
  assign out_if.irms           = irms_r;
  assign out_if.power          = pwr_r;
  assign out_if.error          = err_r;

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && out_if.error) |-> (out_if.irms == '0 && out_if.power == '0
      && out_if.result_channel == '0))
    else $error("error result carries nonzero fields");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (state_r == B_IDLE))
    else $error("job taken while busy");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && !out_if.ready) |=> (out_if.valid && $stable(out_if.irms)))
    else $error("result lost while stalled");

endmodule
`default_nettype wire

// ----- tb/rmc_checker.sv -----
// Checker for the RMS current meter: watches the channels, predicts results and compares them.
`timescale 1ns / 1ps
module rmc_checker
  import rmc_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  rmc_in_if.sink      in_mon,
  rmc_out_if.sink     out_mon,
  rmc_cfg_if.sink     cfg_mon,
  output int          fail_count,
  output int          pending
);

  typedef struct {
    logic [7:0]  result_channel;
    logic [31:0] irms;
    logic [41:0] power;
    logic        error;
  } meter_result_t;

  meter_result_t expected_q[$];

  // Predictor copy of registers and state
  logic        reg_mode;
  logic [11:0] reg_fixed_offset;
  logic [15:0] reg_sample_count;
  logic [31:0] reg_scale;
  logic [9:0]  reg_line_voltage;
  longint      offset_est;
  logic [63:0] sq_sum;
  logic [16:0] win_count;

  function automatic longint floor_div_pow2(longint v, int k);
    if (v >= 0) return v >>> k;
    return -(((-v) + ((longint'(1) << k) - 1)) >>> k);
  endfunction

  function automatic logic [63:0] int_root(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Advance the meter model by one sample
  task automatic predict_sample(logic [7:0] ch, logic [11:0] smp);
    meter_result_t r;
    longint s16;
    longint diff;
    logic [63:0] mag;
    logic [16:0] n;
    logic [16:0] lim;
    logic [63:0] mean;
    logic [127:0] amps;
    if (ch >= CHANNELS) begin
      r.result_channel = '0; r.irms = '0; r.power = '0; r.error = 1'b1;
      expected_q.push_back(r);
      return;
    end
    if (reg_mode == MODE_TRACK) begin
      s16 = longint'(smp) << 16;
      offset_est = offset_est + floor_div_pow2(s16 - offset_est, 10);
      diff = floor_div_pow2(s16 - offset_est, 8);
    end else begin
      diff = (longint'(smp) - longint'(reg_fixed_offset)) * 256;
    end
    mag = diff < 0 ? -diff : diff;
    sq_sum = sq_sum + mag * mag;
    n = win_count + 1;
    lim = reg_sample_count == 0 ? 17'd65536 : {1'b0, reg_sample_count};
    if (n < lim) begin
      win_count = n;
      return;
    end
    mean = sq_sum / n;
    amps = (128'(int_root(mean << 16)) * reg_scale) >> 16;
    if (amps > 128'hFFFF_FFFF) amps = 128'hFFFF_FFFF;
    r.result_channel = ch;
    r.irms = amps[31:0];
    r.power = 42'(amps[31:0] * 64'(reg_line_voltage));
    r.error = 1'b0;
    expected_q.push_back(r);
    sq_sum = 0;
    win_count = 0;
  endtask

  assign pending = expected_q.size();

  // Watch every channel at the rising edge
  always @(posedge clk) begin
    meter_result_t e;
    if (!rst_n) begin
      reg_mode = MODE_TRACK; reg_fixed_offset = 12'd2048; reg_sample_count = 16'd1024;
      reg_scale = 32'd65536; reg_line_voltage = 10'd230;
      offset_est = longint'(2048) << 16; sq_sum = 0; win_count = 0;
      expected_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          REG_MODE:         reg_mode = cfg_mon.data[0];
          REG_FIXED_OFFSET: reg_fixed_offset = cfg_mon.data[11:0];
          REG_SAMPLE_COUNT: reg_sample_count = cfg_mon.data[15:0];
          REG_SCALE:        reg_scale = cfg_mon.data;
          REG_LINE_VOLTAGE: reg_line_voltage = cfg_mon.data[9:0];
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result transaction");
          fail_count++;
        end else begin
          e = expected_q.pop_front();
          if (out_mon.result_channel !== e.result_channel) begin
            $error("result_channel expected %0d actual %0d", e.result_channel,
                   out_mon.result_channel);
            fail_count++;
          end
          if (out_mon.irms !== e.irms) begin
            $error("irms expected %0d actual %0d", e.irms, out_mon.irms);
            fail_count++;
          end
          if (out_mon.power !== e.power) begin
            $error("power expected %0d actual %0d", e.power, out_mon.power);
            fail_count++;
          end
          if (out_mon.error !== e.error) begin
            $error("error expected %0d actual %0d", e.error, out_mon.error);
            fail_count++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) predict_sample(in_mon.channel, in_mon.sample);
    end
  end

endmodule

// ----- tb/rms_current_meter_top_test.sv -----
// Testbench top for the RMS current meter: clock, reset, stimulus phases and verdict.
`timescale 1ns / 1ps
module rms_current_meter_top_test;
  import rmc_pkg::*;

  localparam int IDLE_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 200;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count;
  int   pending;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   idle_cycles = 0;
  logic timed_out = 1'b0;

  rmc_in_if  in_ch();
  rmc_out_if out_ch();
  rmc_cfg_if cfg_ch();

  rms_current_meter_top uut (
    .clk(clk), .rst_n(rst_n), .in_if(in_ch.sink), .out_if(out_ch.source), .cfg_if(cfg_ch.sink)
  );

  rmc_checker checker_i (
    .clk(clk), .rst_n(rst_n), .in_mon(in_ch.sink), .out_mon(out_ch.sink),
    .cfg_mon(cfg_ch.sink), .fail_count(fail_count), .pending(pending)
  );

  always #2 clk = ~clk;

  initial begin
    in_ch.valid = 1'b0; in_ch.channel = '0; in_ch.sample = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0; cfg_ch.index = '0; cfg_ch.data = '0;
  end

  // Stall the receiver at random
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT && !timed_out) begin
      timed_out <= 1'b1;
      $display("TEST FAILED");
      $finish;
    end
  end

  // Hold until every result has arrived and the back end has drained
  task automatic wait_quiet();
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write a register once nothing is in flight
  task automatic write_reg(logic [7:0] idx, logic [31:0] val);
    wait_quiet();
    @(posedge clk);
    cfg_ch.valid <= 1'b1; cfg_ch.index <= idx; cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic send_sample(logic [7:0] ch, logic [11:0] smp);
    @(posedge clk);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    in_ch.valid <= 1'b1; in_ch.channel <= ch; in_ch.sample <= smp;
    do @(posedge clk); while (!in_ch.ready);
    in_ch.valid <= 1'b0;
  endtask

  // Mostly valid channels, a few out of range
  task automatic send_random(int count, int full_range);
    logic [7:0] ch;
    logic [11:0] smp;
    for (int i = 0; i < count; i++) begin
      ch = ($urandom_range(19) == 0) ? 8'($urandom_range(255, CHANNELS))
                                     : 8'($urandom_range(CHANNELS - 1));
      smp = full_range ? 12'($urandom) : 12'(2048 + $signed($urandom_range(1600)) - 800);
      send_sample(ch, smp);
    end
  endtask

  task automatic set_idling(int phase);
    case (phase % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
      default: begin send_idle_pct = 37; recv_stall_pct = 37; end
    endcase
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: short windows, extreme samples and channels
    write_reg(REG_SAMPLE_COUNT, 32'd1);
    send_sample(8'd0, 12'd0);
    send_sample(8'd7, 12'd4095);
    send_sample(8'd255, 12'd4095);
    send_sample(8'd8, 12'd0);
    send_sample(8'd3, 12'd2048);
    write_reg(REG_MODE, {31'd0, MODE_FIXED});
    write_reg(REG_FIXED_OFFSET, 32'd0);
    send_sample(8'd1, 12'd4095);
    write_reg(REG_FIXED_OFFSET, 32'd4095);
    send_sample(8'd2, 12'd0);
    write_reg(REG_SCALE, 32'hFFFF_FFFF);
    write_reg(REG_LINE_VOLTAGE, 32'd1023);
    send_sample(8'd4, 12'd0);
    write_reg(REG_SCALE, 32'd0);
    write_reg(REG_LINE_VOLTAGE, 32'd0);
    send_sample(8'd5, 12'd1234);
    write_reg(REG_SCALE, 32'h0003_0000);
    write_reg(REG_LINE_VOLTAGE, 32'd230);
    write_reg(REG_SAMPLE_COUNT, 32'd4);
    send_sample(8'd6, 12'd100);
    send_sample(8'd6, 12'd3000);
    // Mode change mid-window
    write_reg(REG_MODE, {31'd0, MODE_TRACK});
    send_sample(8'd6, 12'd3900);
    send_sample(8'd6, 12'd10);
    // Window length lowered mid-window
    write_reg(REG_SAMPLE_COUNT, 32'd8);
    send_sample(8'd1, 12'd2500);
    send_sample(8'd1, 12'd1500);
    send_sample(8'd1, 12'd2200);
    write_reg(REG_SAMPLE_COUNT, 32'd2);
    send_sample(8'd1, 12'd2700);
    wait_quiet();

    // Random phases through several settings
    for (int ph = 0; ph < 8; ph++) begin
      set_idling(ph);
      write_reg(REG_MODE, 32'($urandom_range(1)));
      write_reg(REG_FIXED_OFFSET, (ph == 2) ? 32'd4095 : 32'($urandom_range(4095)));
      write_reg(REG_SAMPLE_COUNT, 32'($urandom_range(16, 1)));
      write_reg(REG_SCALE, (ph == 5) ? 32'hFFFF_FFFF : $urandom);
      write_reg(REG_LINE_VOLTAGE, (ph == 6) ? 32'd1023 : 32'($urandom_range(1023)));
      send_random(120, ph % 2);
      wait_quiet();
    end

    // Zero window length means 65536 samples, then close the window
    set_idling(0);
    write_reg(REG_MODE, {31'd0, MODE_FIXED});
    write_reg(REG_SAMPLE_COUNT, 32'd0);
    send_random(100, 1);
    write_reg(REG_SAMPLE_COUNT, 32'd1);
    send_sample(8'd0, 12'd4000);
    wait_quiet();
    write_reg(REG_SAMPLE_COUNT, 32'd65535);
    write_reg(REG_SAMPLE_COUNT, 32'd3);
    send_random(40, 1);
    wait_quiet();

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/rmc_pkg.sv
hw/rtl/rmc_if.sv
hw/rtl/rmc_front.sv
hw/rtl/rmc_queue.sv
hw/rtl/rmc_back.sv
hw/rtl/rms_current_meter_top.sv
tb/rmc_checker.sv
tb/rms_current_meter_top_test.sv
